// ===== src/bounded_double_ended_queue_unit_macros.svh =====
// Assertion macros used by the checker file of the deque unit.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define BDQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, off while reset is asserted.
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== src/bdq_pkg.sv =====
`timescale 1ns / 1ps
package bdq_pkg;

  localparam int OP_W      = 3;
  localparam int CAP_W     = 9;
  localparam int CAP_RESET = 256;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;  // apply the accepted operation to the ring
    logic load;  // fill the output register
  } dp_cmd_t;

endpackage

// ===== src/bdq_ctrl.sv =====
`timescale 1ns / 1ps
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.exec  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // wait for the output register to drain
        if (!out_valid_r || out_tready) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== src/bdq_datapath.sv =====
`timescale 1ns / 1ps
module bdq_datapath
  import bdq_pkg::*;
#(
  parameter int STORE_DEPTH = 256,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [OP_W-1:0]       op,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic                  cfg_we,
  input  logic [CAP_W-1:0]      cfg_data,
  output logic                  res_accepted,
  output logic [DATA_WIDTH-1:0] res_front,
  output logic [DATA_WIDTH-1:0] res_rear,
  output logic                  res_empty,
  output logic                  res_full
);

  localparam int IW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int SW = IW + 2;
  localparam logic [SW-1:0] DEPTH_S = SW'(STORE_DEPTH);
  localparam int CAP_RST = (CAP_RESET > STORE_DEPTH) ? STORE_DEPTH : CAP_RESET;

  logic [DATA_WIDTH-1:0] mem [STORE_DEPTH];

  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] eff_cap_r;
  logic          acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] rd_front_r, rd_rear_r;
  logic [DATA_WIDTH-1:0] out_front_r, out_rear_r;
  logic          out_acc_r, out_empty_r, out_full_r;

  logic          full, empty;
  logic [IW-1:0] front_dec, front_inc, back_pos, rear_pos;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0]   cap_sat;

  // One conditional subtract: the sum is always below twice the depth.
  function automatic logic [IW-1:0] wrap(input logic [SW-1:0] p);
    logic [SW-1:0] q;
    q = (p >= DEPTH_S) ? p - DEPTH_S : p;
    return q[IW-1:0];
  endfunction

  always_comb begin
    full      = (count_r >= eff_cap_r);
    empty     = (count_r == '0);
    front_dec = (front_r == '0) ? IW'(STORE_DEPTH - 1) : front_r - 1'b1;
    front_inc = (front_r == IW'(STORE_DEPTH - 1)) ? '0 : front_r + 1'b1;
    back_pos  = wrap(SW'(front_r) + SW'(count_r));
    rear_pos  = empty ? front_r : wrap(SW'(front_r) + SW'(count_r) - SW'(1));

    front_nxt = front_r;
    count_nxt = count_r;
    acc_nxt   = acc_r;
    wr_en     = 1'b0;
    wr_addr   = back_pos;
    if (cmd.exec) begin
      acc_nxt = 1'b1;
      case (op)
        OP_PUSH_FRONT: begin
          if (full) begin
            acc_nxt = 1'b0;
          end else begin
            front_nxt = front_dec;
            wr_en     = 1'b1;
            wr_addr   = front_dec;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            acc_nxt = 1'b0;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            acc_nxt = 1'b0;
          end else begin
            front_nxt = front_inc;
            count_nxt = count_r - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            acc_nxt = 1'b0;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          acc_nxt = 1'b1;
        end
      endcase
    end

    // clamp capacity into 1..STORE_DEPTH
    cap_sat = 32'(cfg_data);
    if (cap_sat == 32'd0) begin
      cap_sat = 32'd1;
    end
    if (cap_sat > 32'(STORE_DEPTH)) begin
      cap_sat = 32'(STORE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r   <= '0;
      count_r   <= '0;
      eff_cap_r <= CW'(CAP_RST);
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        eff_cap_r <= CW'(cap_sat);
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
    rd_front_r <= mem[front_r];
    rd_rear_r  <= mem[rear_pos];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_acc_r   <= acc_r;
      out_front_r <= empty ? '1 : rd_front_r;
      out_rear_r  <= empty ? '1 : rd_rear_r;
      out_empty_r <= empty;
      out_full_r  <= full;
    end
  end

  assign res_accepted = out_acc_r;
  assign res_front    = out_front_r;
  assign res_rear     = out_rear_r;
  assign res_empty    = out_empty_r;
  assign res_full     = out_full_r;

endmodule

// ===== src/bounded_double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// Bounded double-ended queue on a ring buffer.
// in_*  : one transaction per operation; tdata = {value, operation}. Codes:
//         push front, push back, pop front, pop back; anything else only
//         reports status.
// out_* : exactly one result transaction per input transaction, in order.
//         tdata = {is_full, is_empty, rear_value, front_value, accepted}.
//         Refused pushes (full) and pops (empty) return accepted = 0 and
//         leave the queue untouched. Empty queue reports all-ones values.
// cfg_* : capacity write, clamped to 1..STORE_DEPTH. Write only while idle;
//         a capacity below the current fill keeps all entries and reads full.
// Steps: the ring is written in the accept state, front and rear are
//         read from the entry memory through its registered read ports
//         in the read state, and the output register loads in the load
//         state. A new operation is taken only once the previous one has
//         loaded; in_tready returns with the output register still full.
// Stall: while out_tready is low the result holds; a following item is
//         taken and waits in the load step until the result is taken.
// Reset: empty queue, front index 0, capacity 256 (or STORE_DEPTH if
//         smaller). Memory contents are not cleared; no clearing pass.
module bounded_double_ended_queue_unit
  import bdq_pkg::*;
#(
  parameter int STORE_DEPTH = 256,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // [2:0] operation, [DATA_WIDTH+2:3] value, zero pad above
  input  logic [((OP_W + DATA_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // [0] accepted, front_value, rear_value, is_empty, is_full, zero pad above
  output logic [((2 * DATA_WIDTH + 3 + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [CAP_W-1:0]                        cfg_data
);

  localparam int OUT_W = ((2 * DATA_WIDTH + 3 + 7) / 8) * 8;

  dp_cmd_t               cmd;
  logic                  res_accepted, res_empty, res_full;
  logic [DATA_WIDTH-1:0] res_front, res_rear;

  // Capacity register is always writable.
  assign cfg_ready = 1'b1;

  bdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bdq_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .op           (in_tdata[OP_W-1:0]),
    .value        (in_tdata[OP_W +: DATA_WIDTH]),
    .cfg_we       (cfg_valid),
    .cfg_data     (cfg_data),
    .res_accepted (res_accepted),
    .res_front    (res_front),
    .res_rear     (res_rear),
    .res_empty    (res_empty),
    .res_full     (res_full)
  );

  // Pack the result, zero fill up to the byte boundary.
  assign out_tdata = OUT_W'({res_full, res_empty, res_rear, res_front, res_accepted});

endmodule

// ===== src/bdq_checker.sv =====
`timescale 1ns / 1ps
`include "bounded_double_ended_queue_unit_macros.svh"
module bdq_checker
  import bdq_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_tvalid,
  input logic                                    in_tready,
  input logic                                    out_tvalid,
  input logic                                    out_tready,
  input logic [((2 * DATA_WIDTH + 3 + 7) / 8) * 8 - 1:0] out_tdata
);

  logic                  o_acc, o_empty, o_full;
  logic [DATA_WIDTH-1:0] o_front, o_rear;

  assign o_acc   = out_tdata[0];
  assign o_front = out_tdata[DATA_WIDTH:1];
  assign o_rear  = out_tdata[2 * DATA_WIDTH:DATA_WIDTH + 1];
  assign o_empty = out_tdata[2 * DATA_WIDTH + 1];
  assign o_full  = out_tdata[2 * DATA_WIDTH + 2];

  // A stalled result holds.
  `BDQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // One operation in flight: no accept right after an accept.
  `BDQ_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // An empty queue reports all-ones values and is never full.
  `BDQ_ASSERT_IMPLY(a_empty_view, clk, rst_n, out_tvalid && o_empty, (&o_front) && (&o_rear) && !o_full)
  // A refusal only happens at a full or empty queue, which it leaves so.
  `BDQ_ASSERT_IMPLY(a_refuse_edge, clk, rst_n, out_tvalid && !o_acc, o_empty || o_full)

endmodule

bind bounded_double_ended_queue_unit bdq_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_bdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
